### sv/pjb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer package
// Shared widths, request and register codes, the table entry type and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pjb_pkg;

    localparam int DEPTH      = 16;
    // One slot beyond DEPTH holds a new packet pushed into a full table.
    localparam int SLOTS      = DEPTH + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int FILL_W     = $clog2(SLOTS + 1);

    localparam int REQ_W      = 2;
    localparam int SEQ_W      = 16;
    localparam int HANDLE_W   = 16;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 5;
    localparam int FILL_OUT_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam int CMP_A      = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int CMP_W      = (CMP_A > FILL_OUT_W) ? CMP_A : FILL_OUT_W;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FILL    = 1'd1;

    localparam logic [CFG_W-1:0] TARGET_FILL_RST = 5'd4;
    localparam logic [CFG_W-1:0] MAX_FILL_RST    = 5'd16;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic key_exp;
        logic write_entry;
        logic start_play;
        logic drop_min;
        logic pop_finish;
        logic clear;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             len_zero;
        logic             started;
        logic             scan_done;
        logic             start_cond;
        logic             over_limit;
        logic             out_free;
    } t_sts;

endpackage

### sv/pjb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pjb_req_if;
    logic                          valid;
    logic                          ready;
    logic [pjb_pkg::REQ_W-1:0]     req_type;
    logic [pjb_pkg::SEQ_W-1:0]     seq_num;
    logic [pjb_pkg::HANDLE_W-1:0]  payload_handle;
    logic [pjb_pkg::LEN_W-1:0]     payload_len;

    modport source (output valid, req_type, seq_num, payload_handle, payload_len,
                    input ready);
    modport sink   (input valid, req_type, seq_num, payload_handle, payload_len,
                    output ready);
endinterface

interface pjb_res_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [pjb_pkg::HANDLE_W-1:0]    out_handle;
    logic [pjb_pkg::LEN_W-1:0]       out_len;
    logic [pjb_pkg::FILL_OUT_W-1:0]  fill_count;
    logic [pjb_pkg::CNT_W-1:0]       late_count;
    logic [pjb_pkg::CNT_W-1:0]       lost_count;
    logic                            playing;

    modport source (output valid, found, out_handle, out_len, fill_count,
                    late_count, lost_count, playing, input ready);
    modport sink   (input valid, found, out_handle, out_len, fill_count,
                    late_count, lost_count, playing, output ready);
endinterface

interface pjb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pjb_pkg::CFG_IDX_W-1:0]  index;
    logic [pjb_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/pjb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer controller
// Sequences each request through table scans, the entry write, the playback
// start, the drop loop, the table clear and the result hand-off.
// ----------------------------------------------------------------------------
module pjb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output pjb_pkg::t_cmd o_cmd,
    input  pjb_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH_SCAN,
        ST_PUSH_WR,
        ST_CHECK,
        ST_START_SCAN,
        ST_START_SET,
        ST_DROP_SCAN,
        ST_DROP,
        ST_POP_SCAN,
        ST_POP_FIN,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.req_type)
                    pjb_pkg::REQ_PUSH: begin
                        if (i_sts.len_zero) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_PUSH_SCAN;
                        end
                    end
                    pjb_pkg::REQ_POP: begin
                        if (!i_sts.started) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.key_exp    = 1'b1;
                            n_state          = ST_POP_SCAN;
                        end
                    end
                    pjb_pkg::REQ_RESET: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_PUSH_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_PUSH_WR;
                end
            end
            ST_PUSH_WR: begin
                o_cmd.write_entry = 1'b1;
                n_state           = ST_CHECK;
            end
            ST_CHECK: begin
                // The start check comes first; after it only drops remain.
                if (i_sts.start_cond) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_START_SCAN;
                end else if (i_sts.over_limit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_DROP_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_START_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_START_SET;
                end
            end
            ST_START_SET: begin
                o_cmd.start_play = 1'b1;
                n_state          = ST_CHECK;
            end
            ST_DROP_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                o_cmd.drop_min = 1'b1;
                n_state        = ST_CHECK;
            end
            ST_POP_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_POP_FIN;
                end
            end
            ST_POP_FIN: begin
                o_cmd.pop_finish = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/pjb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer datapath
// Entry table memory with valid bits, the scan unit that finds a key match,
// the first free slot and the smallest sequence number, the play state,
// the saturating counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pjb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pjb_pkg::REQ_W-1:0]         i_req_type,
    input  logic [pjb_pkg::SEQ_W-1:0]         i_seq_num,
    input  logic [pjb_pkg::HANDLE_W-1:0]      i_payload_handle,
    input  logic [pjb_pkg::LEN_W-1:0]         i_payload_len,
    input  logic                              i_cfg_we,
    input  logic [pjb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pjb_pkg::CFG_W-1:0]         i_cfg_data,
    input  pjb_pkg::t_cmd                     i_cmd,
    output pjb_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [pjb_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [pjb_pkg::LEN_W-1:0]         o_out_len,
    output logic [pjb_pkg::FILL_OUT_W-1:0]    o_fill_count,
    output logic [pjb_pkg::CNT_W-1:0]         o_late_count,
    output logic [pjb_pkg::CNT_W-1:0]         o_lost_count,
    output logic                              o_playing
);

    // Configuration
    logic [pjb_pkg::CFG_W-1:0] r_target_fill;
    logic [pjb_pkg::CFG_W-1:0] r_max_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_fill <= pjb_pkg::TARGET_FILL_RST;
            r_max_fill    <= pjb_pkg::MAX_FILL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pjb_pkg::REG_TARGET_FILL: r_target_fill <= i_cfg_data;
                pjb_pkg::REG_MAX_FILL:    r_max_fill    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request holding registers
    logic [pjb_pkg::REQ_W-1:0]    r_req_type;
    logic [pjb_pkg::SEQ_W-1:0]    r_seq;
    logic [pjb_pkg::HANDLE_W-1:0] r_handle;
    logic [pjb_pkg::LEN_W-1:0]    r_len;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_seq      <= i_seq_num;
            r_handle   <= i_payload_handle;
            r_len      <= i_payload_len;
        end
    end

    // Table state
    logic [pjb_pkg::SLOTS-1:0]  r_valid;
    logic [pjb_pkg::FILL_W-1:0] r_fill;
    logic [pjb_pkg::SEQ_W-1:0]  r_expected;
    logic                       r_started;
    logic [pjb_pkg::CNT_W-1:0]  r_late;
    logic [pjb_pkg::CNT_W-1:0]  r_lost;

    // Scan unit
    logic                        r_scan_run;
    logic [pjb_pkg::SLOT_W-1:0]  r_scan_addr;
    logic                        r_rd_vld;
    logic [pjb_pkg::SLOT_W-1:0]  r_rd_idx;
    logic                        r_rd_ent_vld;
    pjb_pkg::t_entry             r_rd_data;
    logic [pjb_pkg::SEQ_W-1:0]   r_key;

    logic                        r_hit;
    logic [pjb_pkg::SLOT_W-1:0]  r_hit_idx;
    logic [pjb_pkg::HANDLE_W-1:0] r_hit_handle;
    logic [pjb_pkg::LEN_W-1:0]   r_hit_len;
    logic                        r_min_found;
    logic [pjb_pkg::SLOT_W-1:0]  r_min_idx;
    logic [pjb_pkg::SEQ_W-1:0]   r_min_seq;
    logic                        r_free_found;
    logic [pjb_pkg::SLOT_W-1:0]  r_free_idx;

    // Entry memory
    pjb_pkg::t_entry             r_mem [pjb_pkg::SLOTS];
    logic [pjb_pkg::SLOT_W-1:0]  w_wr_slot;
    pjb_pkg::t_entry             w_wr_entry;

    assign w_wr_slot  = r_hit ? r_hit_idx : r_free_idx;
    assign w_wr_entry = '{seq: r_seq, handle: r_handle, len: r_len};

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_mem[w_wr_slot] <= w_wr_entry;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_run  <= 1'b0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_run  <= 1'b1;
                r_scan_addr <= '0;
            end else if (r_scan_run) begin
                if (r_scan_addr == pjb_pkg::SLOT_W'(pjb_pkg::SLOTS - 1)) begin
                    r_scan_run <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + pjb_pkg::SLOT_W'(1);
                end
            end
            r_rd_vld <= r_scan_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_scan_addr;
        r_rd_ent_vld <= r_valid[r_scan_addr];
        if (i_cmd.scan_start) begin
            r_key <= i_cmd.key_exp ? r_expected : r_seq;
        end
    end

    // Match, minimum and first free slot are gathered in one pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_min_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_hit        <= 1'b0;
            r_min_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_ent_vld) begin
                if (r_rd_data.seq == r_key) begin
                    r_hit        <= 1'b1;
                    r_hit_idx    <= r_rd_idx;
                    r_hit_handle <= r_rd_data.handle;
                    r_hit_len    <= r_rd_data.len;
                end
                if (!r_min_found || (r_rd_data.seq < r_min_seq)) begin
                    r_min_found <= 1'b1;
                    r_min_idx   <= r_rd_idx;
                    r_min_seq   <= r_rd_data.seq;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
    end

    // Per-request result fields
    logic                         r_found;
    logic [pjb_pkg::HANDLE_W-1:0] r_res_handle;
    logic [pjb_pkg::LEN_W-1:0]    r_res_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_fill       <= '0;
            r_expected   <= '0;
            r_started    <= 1'b0;
            r_late       <= '0;
            r_lost       <= '0;
            r_found      <= 1'b0;
            r_res_handle <= '0;
            r_res_len    <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_found      <= 1'b0;
                r_res_handle <= '0;
                r_res_len    <= '0;
            end
            if (i_cmd.write_entry) begin
                r_valid[w_wr_slot] <= 1'b1;
                if (!r_hit) begin
                    r_fill <= r_fill + pjb_pkg::FILL_W'(1);
                end
            end
            if (i_cmd.start_play && r_min_found) begin
                r_expected <= r_min_seq;
            end
            if (i_cmd.start_play) begin
                r_started <= 1'b1;
            end
            if (i_cmd.drop_min) begin
                r_valid[r_min_idx] <= 1'b0;
                r_fill             <= r_fill - pjb_pkg::FILL_W'(1);
                // A dropped entry is late when playback has not started or it lies
                // below the expected sequence number.
                if ((!r_started || (r_min_seq < r_expected)) && (r_late != '1)) begin
                    r_late <= r_late + pjb_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.pop_finish) begin
                if (r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_fill             <= r_fill - pjb_pkg::FILL_W'(1);
                    r_found            <= 1'b1;
                    r_res_handle       <= r_hit_handle;
                    r_res_len          <= r_hit_len;
                end else if (r_lost != '1) begin
                    r_lost <= r_lost + pjb_pkg::CNT_W'(1);
                end
                r_expected <= r_expected + pjb_pkg::SEQ_W'(1);
            end
            if (i_cmd.clear) begin
                r_valid    <= '0;
                r_fill     <= '0;
                r_expected <= '0;
                r_started  <= 1'b0;
            end
        end
    end

    // Fill comparisons
    logic [pjb_pkg::CMP_W-1:0] w_fill_ext;
    logic [pjb_pkg::CMP_W-1:0] w_max_ext;
    logic [pjb_pkg::CMP_W-1:0] w_limit;

    assign w_fill_ext = pjb_pkg::CMP_W'(r_fill);
    assign w_max_ext  = pjb_pkg::CMP_W'(r_max_fill);
    assign w_limit    = (w_max_ext < pjb_pkg::CMP_W'(pjb_pkg::DEPTH))
                        ? w_max_ext : pjb_pkg::CMP_W'(pjb_pkg::DEPTH);

    // Result register
    logic                           r_out_vld;
    logic                           r_out_found;
    logic [pjb_pkg::HANDLE_W-1:0]   r_out_handle;
    logic [pjb_pkg::LEN_W-1:0]      r_out_len;
    logic [pjb_pkg::FILL_OUT_W-1:0] r_out_fill;
    logic [pjb_pkg::CNT_W-1:0]      r_out_late;
    logic [pjb_pkg::CNT_W-1:0]      r_out_lost;
    logic                           r_out_playing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_found   <= r_found;
            r_out_handle  <= r_res_handle;
            r_out_len     <= r_res_len;
            r_out_fill    <= w_fill_ext[pjb_pkg::FILL_OUT_W-1:0];
            r_out_late    <= r_late;
            r_out_lost    <= r_lost;
            r_out_playing <= r_started;
        end
    end

    assign o_sts.req_type   = r_req_type;
    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.started    = r_started;
    assign o_sts.scan_done  = r_rd_vld && (r_rd_idx == pjb_pkg::SLOT_W'(pjb_pkg::SLOTS - 1));
    assign o_sts.start_cond = !r_started && (w_fill_ext >= pjb_pkg::CMP_W'(r_target_fill));
    assign o_sts.over_limit = (w_fill_ext > w_limit);
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_found      = r_out_found;
    assign o_out_handle = r_out_handle;
    assign o_out_len    = r_out_len;
    assign o_fill_count = r_out_fill;
    assign o_late_count = r_out_late;
    assign o_lost_count = r_out_lost;
    assign o_playing    = r_out_playing;

endmodule

### sv/packet_jitter_buffer.sv
`timescale 1ns / 1ps
// Steps: a reset request or ignored request goes straight to the result; a pop runs one table scan.
// A push runs one table scan, plus one more for the start check and one for each dropped entry.
// Each table scan reads one entry per cycle through the single read port of the entry memory.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset is synchronous and active low: it empties the table, clears play state and counters and
// restores target_fill 4 and max_fill 16 at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Packet jitter buffer
// Sequence-keyed descriptor table with playback start, overflow drop and
// saturating late and loss counters.
// ----------------------------------------------------------------------------
module packet_jitter_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pjb_req_if.sink     i_req,
    pjb_res_if.source   o_res,
    pjb_cfg_if.sink     i_cfg
);

    pjb_pkg::t_cmd w_cmd;
    pjb_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_req.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    pjb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    pjb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_type       (i_req.req_type),
        .i_seq_num        (i_req.seq_num),
        .i_payload_handle (i_req.payload_handle),
        .i_payload_len    (i_req.payload_len),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_res.valid),
        .i_out_ready      (o_res.ready),
        .o_found          (o_res.found),
        .o_out_handle     (o_res.out_handle),
        .o_out_len        (o_res.out_len),
        .o_fill_count     (o_res.fill_count),
        .o_late_count     (o_res.late_count),
        .o_lost_count     (o_res.lost_count),
        .o_playing        (o_res.playing)
    );

endmodule

### sv/pjb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pjb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_found,
    input logic [pjb_pkg::HANDLE_W-1:0]   i_out_handle,
    input logic [pjb_pkg::LEN_W-1:0]      i_out_len,
    input logic [pjb_pkg::FILL_OUT_W-1:0] i_fill_count,
    input logic [pjb_pkg::CNT_W-1:0]      i_late_count,
    input logic [pjb_pkg::CNT_W-1:0]      i_lost_count,
    input logic                           i_playing
);

    // Counters of the last result transaction; they only grow.
    logic                      r_have_prev;
    logic [pjb_pkg::CNT_W-1:0] r_prev_late;
    logic [pjb_pkg::CNT_W-1:0] r_prev_lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_late <= '0;
            r_prev_lost <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_have_prev <= 1'b1;
            r_prev_late <= i_late_count;
            r_prev_lost <= i_lost_count;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_fill_count) <= 32'(pjb_pkg::DEPTH)))
        else $error("fill_count above table depth");

    a_found_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> i_playing)
        else $error("packet returned while not playing");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> ((i_out_handle == '0) && (i_out_len == '0)))
        else $error("descriptor nonzero on a result without a packet");

    a_counters_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_have_prev) |->
            ((i_late_count >= r_prev_late) && (i_lost_count >= r_prev_lost)))
        else $error("late or lost counter went backward");

endmodule

bind packet_jitter_buffer pjb_checker u_pjb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_found      (o_res.found),
    .i_out_handle (o_res.out_handle),
    .i_out_len    (o_res.out_len),
    .i_fill_count (o_res.fill_count),
    .i_late_count (o_res.late_count),
    .i_lost_count (o_res.lost_count),
    .i_playing    (o_res.playing)
);

### tb/tb_packet_jitter_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet jitter buffer testbench
// Drives push, pop, reset and unused requests through the request channel
// and rewrites target_fill and max_fill between phases. A scoreboard keeps
// its own copy of the sequence table and predicts every status transaction.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_packet_jitter_buffer;

    localparam logic [pjb_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int END_WAIT    = 2 * pjb_pkg::DEPTH + 32;

    typedef struct packed {
        logic [pjb_pkg::REQ_W-1:0]    kind;
        logic [pjb_pkg::SEQ_W-1:0]    seq;
        logic [pjb_pkg::HANDLE_W-1:0] handle;
        logic [pjb_pkg::LEN_W-1:0]    len;
    } t_request;

    typedef struct packed {
        logic                           found;
        logic [pjb_pkg::HANDLE_W-1:0]   handle;
        logic [pjb_pkg::LEN_W-1:0]      len;
        logic [pjb_pkg::FILL_OUT_W-1:0] fill;
        logic [pjb_pkg::CNT_W-1:0]      late;
        logic [pjb_pkg::CNT_W-1:0]      lost;
        logic                           playing;
    } t_status;

    typedef enum int {READY_FREE, READY_COIN, READY_SPARSE, READY_PERIODIC} t_ready_mode;

    // Predicts the status of every request from a private copy of the table.
    class t_table_model;
        bit                        used[pjb_pkg::SLOTS];
        pjb_pkg::t_entry           entry[pjb_pkg::SLOTS];
        logic [pjb_pkg::SEQ_W-1:0] play_seq;
        bit                        playing;
        logic [pjb_pkg::CNT_W-1:0] late_total;
        logic [pjb_pkg::CNT_W-1:0] lost_total;
        logic [pjb_pkg::CFG_W-1:0] start_level;
        logic [pjb_pkg::CFG_W-1:0] fill_cap;
        t_status                   pending[$];
        int                        failures;

        function void clear_table();
            foreach (used[i]) begin
                used[i]  = 1'b0;
                entry[i] = '0;
            end
        endfunction

        function void power_up();
            clear_table();
            play_seq    = '0;
            playing     = 1'b0;
            late_total  = '0;
            lost_total  = '0;
            start_level = pjb_pkg::TARGET_FILL_RST;
            fill_cap    = pjb_pkg::MAX_FILL_RST;
            pending.delete();
            failures    = 0;
        endfunction

        function void write_register(logic [pjb_pkg::CFG_IDX_W-1:0] idx,
                                     logic [pjb_pkg::CFG_W-1:0] data);
            if (idx == pjb_pkg::REG_TARGET_FILL) begin
                start_level = data;
            end else if (idx == pjb_pkg::REG_MAX_FILL) begin
                fill_cap = data;
            end
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (used[i]) begin
                if (used[i]) n++;
            end
            return n;
        endfunction

        function int slot_of(logic [pjb_pkg::SEQ_W-1:0] s);
            foreach (used[i]) begin
                if (used[i] && entry[i].seq == s) return i;
            end
            return -1;
        endfunction

        function int oldest_slot();
            int best;
            best = -1;
            foreach (used[i]) begin
                if (used[i] && (best < 0 || entry[i].seq < entry[best].seq)) best = i;
            end
            return best;
        endfunction

        function logic [pjb_pkg::CNT_W-1:0] bump(logic [pjb_pkg::CNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void store_packet(t_request r);
            int slot;
            int limit;
            int m;
            limit = (fill_cap < pjb_pkg::DEPTH) ? int'(fill_cap) : pjb_pkg::DEPTH;
            if (r.len == 0) return;
            slot = slot_of(r.seq);
            // A new number in a full table lands in the spare slot for a moment.
            for (int i = 0; i < pjb_pkg::SLOTS && slot < 0; i++) begin
                if (!used[i]) slot = i;
            end
            used[slot]  = 1'b1;
            entry[slot] = '{seq: r.seq, handle: r.handle, len: r.len};
            if (!playing && occupancy() >= start_level) begin
                m        = oldest_slot();
                play_seq = entry[m].seq;
                playing  = 1'b1;
            end
            while (occupancy() > limit) begin
                m = oldest_slot();
                if (!playing || entry[m].seq < play_seq) late_total = bump(late_total);
                used[m] = 1'b0;
            end
        endfunction

        function void note_request(t_request r);
            t_status want;
            int      k;
            want = '0;
            case (r.kind)
                pjb_pkg::REQ_PUSH: store_packet(r);
                pjb_pkg::REQ_POP: begin
                    if (playing) begin
                        k = slot_of(play_seq);
                        if (k >= 0) begin
                            want.found  = 1'b1;
                            want.handle = entry[k].handle;
                            want.len    = entry[k].len;
                            used[k]     = 1'b0;
                        end else begin
                            lost_total = bump(lost_total);
                        end
                        play_seq = play_seq + 1'b1;
                    end
                end
                pjb_pkg::REQ_RESET: begin
                    clear_table();
                    play_seq = '0;
                    playing  = 1'b0;
                end
                default: ;
            endcase
            want.fill    = pjb_pkg::FILL_OUT_W'(occupancy());
            want.late    = late_total;
            want.lost    = lost_total;
            want.playing = playing;
            pending.push_back(want);
        endfunction

        function void check_status(t_status got);
            t_status want;
            bit      bad;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: status transaction with nothing pending", $time);
                return;
            end
            want = pending.pop_front();
            bad = (got.found !== want.found) || (got.handle !== want.handle) ||
                  (got.len !== want.len) || (got.fill !== want.fill) ||
                  (got.late !== want.late) || (got.lost !== want.lost) ||
                  (got.playing !== want.playing);
            if (bad) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display({"%0t: expected found=%0d handle=%h len=%0d fill=%0d",
                              " late=%0d lost=%0d play=%0d"},
                             $time, want.found, want.handle, want.len, want.fill,
                             want.late, want.lost, want.playing);
                    $display({"%0t: actual   found=%0d handle=%h len=%0d fill=%0d",
                              " late=%0d lost=%0d play=%0d"},
                             $time, got.found, got.handle, got.len, got.fill,
                             got.late, got.lost, got.playing);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pjb_req_if req_if ();
    pjb_res_if res_if ();
    pjb_cfg_if cfg_if ();

    packet_jitter_buffer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_table_model               buffer_model;
    int                         burst_left = 0;
    logic [pjb_pkg::SEQ_W-1:0]  stream_seq;
    t_ready_mode                ready_mode = READY_FREE;
    int                         mode_left  = 0;
    int unsigned                quiet_cycles = 0;
    t_status                    seen;

    always #5 clk = ~clk;

    // Result side: check each status transaction, then pick the next ready value.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            seen.found   = res_if.found;
            seen.handle  = res_if.out_handle;
            seen.len     = res_if.out_len;
            seen.fill    = res_if.fill_count;
            seen.late    = res_if.late_count;
            seen.lost    = res_if.lost_count;
            seen.playing = res_if.playing;
            buffer_model.check_status(seen);
        end
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_FREE:   res_if.ready <= 1'b1;
            READY_COIN:   res_if.ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: res_if.ready <= ($urandom_range(0, 9) == 0);
            default:      res_if.ready <= ((mode_left % 8) < 5);
        endcase
    end

    always @(posedge clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_request make_req(logic [pjb_pkg::REQ_W-1:0] kind,
                                          logic [pjb_pkg::SEQ_W-1:0] seq,
                                          logic [pjb_pkg::HANDLE_W-1:0] handle,
                                          logic [pjb_pkg::LEN_W-1:0] len);
        t_request r;
        r = '{kind: kind, seq: seq, handle: handle, len: len};
        return r;
    endfunction

    // Valid stays high across back-to-back transactions of a burst.
    task automatic send_request(input t_request r);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= r.kind;
        req_if.seq_num        <= r.seq;
        req_if.payload_handle <= r.handle;
        req_if.payload_len    <= r.len;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        buffer_model.note_request(r);
        burst_left--;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (buffer_model.pending.size() != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [pjb_pkg::CFG_W-1:0] tf,
                             input logic [pjb_pkg::CFG_W-1:0] mf);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= pjb_pkg::REG_TARGET_FILL;
        cfg_if.data  <= tf;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        buffer_model.write_register(pjb_pkg::REG_TARGET_FILL, tf);
        cfg_if.index <= pjb_pkg::REG_MAX_FILL;
        cfg_if.data  <= mf;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        buffer_model.write_register(pjb_pkg::REG_MAX_FILL, mf);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic directed_requests();
        // Pop before start, an unused request code, a reset and a zero-length push come first.
        send_request(make_req(pjb_pkg::REQ_POP, 16'h0000, 16'h0000, 11'd0));
        send_request(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 11'h7FF));
        send_request(make_req(pjb_pkg::REQ_RESET, 16'h0000, 16'h0000, 11'd0));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0010, 16'h1111, 11'd0));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'hFFFF, 16'hFFFF, 11'h7FF));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0000, 16'h0000, 11'd1));
        // Overwrite of a stored number, then two pushes, the second of which reaches the target.
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0000, 16'h5A5A, 11'd300));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0002, 16'h0002, 11'd2));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0001, 16'h0001, 11'd1));
        repeat (4) send_request(make_req(pjb_pkg::REQ_POP, 16'h0000, 16'h0000, 11'd0));
        // A number that has already been played.
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h0001, 16'hA5A5, 11'd9));
        send_request(make_req(pjb_pkg::REQ_POP, 16'h0000, 16'h0000, 11'd0));
        send_request(make_req(pjb_pkg::REQ_RESET, 16'h0000, 16'h0000, 11'd0));
        drain();
        // Zero target starts on the first push; a limit of two forces a late drop.
        configure(5'd0, 5'd2);
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h8000, 16'h0800, 11'd5));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h7FFF, 16'h07FF, 11'd6));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h8001, 16'h0801, 11'd7));
        send_request(make_req(pjb_pkg::REQ_POP, 16'h0000, 16'h0000, 11'd0));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'hFFFE, 16'hBEEF, 11'h7FF));
        drain();
        // A zero limit drops every push, and the target can never be reached.
        configure(5'd17, 5'd0);
        send_request(make_req(pjb_pkg::REQ_RESET, 16'h0000, 16'h0000, 11'd0));
        send_request(make_req(pjb_pkg::REQ_PUSH, 16'h1234, 16'h4321, 11'd44));
    endtask

    task automatic run_traffic(input logic [pjb_pkg::CFG_W-1:0] tf,
                               input logic [pjb_pkg::CFG_W-1:0] mf,
                               input int count, input int push_share);
        t_request r;
        int       roll;
        int       pick;
        drain();
        configure(tf, mf);
        stream_seq = ($urandom_range(0, 2) == 0) ? 16'hFFF8 : 16'($urandom);
        if ($urandom_range(0, 1) == 1) send_request(make_req(pjb_pkg::REQ_RESET, '0, '0, '0));
        repeat (count) begin
            roll = $urandom_range(0, 99);
            r    = make_req(pjb_pkg::REQ_POP, 16'($urandom), 16'($urandom), 11'($urandom));
            if (roll < push_share) begin
                r.kind = pjb_pkg::REQ_PUSH;
                pick   = $urandom_range(0, 99);
                // Mostly in order, some reordered, late or duplicated, a few arbitrary.
                if (pick < 60) begin
                    r.seq      = stream_seq;
                    stream_seq = stream_seq + 1'b1;
                end else if (pick < 75) begin
                    r.seq = stream_seq + 16'($urandom_range(1, 4));
                end else if (pick < 88) begin
                    r.seq = stream_seq - 16'($urandom_range(1, 6));
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    r.len = '0;
                end else if (pick == 1) begin
                    r.len = '1;
                end else begin
                    r.len = 11'($urandom_range(1, 2047));
                end
            end else if (roll < 96) begin
                r.kind = pjb_pkg::REQ_POP;
            end else if (roll < 98) begin
                r.kind = pjb_pkg::REQ_RESET;
            end else begin
                r.kind = REQ_UNUSED;
            end
            send_request(r);
        end
    endtask

    initial begin
        buffer_model = new;
        buffer_model.power_up();
        rst_n                 <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.req_type       <= pjb_pkg::REQ_PUSH;
        req_if.seq_num        <= '0;
        req_if.payload_handle <= '0;
        req_if.payload_len    <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= pjb_pkg::REG_TARGET_FILL;
        cfg_if.data           <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        run_traffic(5'd4, 5'd16, 100, 55);
        run_traffic(5'd1, 5'd1, 60, 50);
        run_traffic(5'd16, 5'd16, 110, 70);
        run_traffic(5'd0, 5'd5, 60, 55);
        run_traffic(5'd20, 5'd16, 40, 60);
        run_traffic(5'd3, 5'd0, 40, 60);
        run_traffic(5'd2, 5'd31, 80, 65);
        repeat (2) run_traffic(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), 80, 58);

        drain();
        repeat (END_WAIT) @(posedge clk);
        if (buffer_model.pending.size() != 0) begin
            $display("%0d status transactions never arrived", buffer_model.pending.size());
            buffer_model.failures += buffer_model.pending.size();
        end
        if (buffer_model.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
sv/pjb_pkg.sv
sv/pjb_if.sv
sv/pjb_ctrl.sv
sv/pjb_dp.sv
sv/packet_jitter_buffer.sv
sv/pjb_checker.sv
tb/tb_packet_jitter_buffer.sv
